// ===== src/sfc_pkg.sv =====
package sfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_WORD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_TYPE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_CODE     = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_BAD_CHECK  = 3'd4;

  // header layout: start word, type word, length word
  localparam int HDR_BYTES = 6;
  localparam int MIN_LENGTH = 8;

  typedef struct packed {
    logic [15:0] start_word;
    logic [15:0] message_type;
    logic [6:0]  expected_length;
    logic [7:0]  sensor_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  port;
    logic        sensor_match;
    logic [31:0] value_bits;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } result_t;

  // CRC-16/MODBUS update by one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== src/sfc_if.sv =====
interface sfc_byte_if import sfc_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_first;

  modport source (output valid, output data_byte, output frame_first, input ready);
  modport sink (input valid, input data_byte, input frame_first, output ready);
endinterface

interface sfc_result_if import sfc_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  port;
  logic        sensor_match;
  logic [31:0] value_bits;
  logic [15:0] received_check;
  logic [15:0] computed_check;

  modport source (output valid, output status, output port, output sensor_match,
                  output value_bits, output received_check, output computed_check,
                  input ready);
  modport sink (input valid, input status, input port, input sensor_match,
                input value_bits, input received_check, input computed_check,
                output ready);
endinterface

// ===== src/sensor_frame_checker_crc16.sv =====
// An accepted byte is held in the input register; its result (if any) is loaded
// into the result register when the input stage advances.
// Throughput: one byte per cycle while the result register is free or draining;
// the byte-wide CRC update is XOR logic between the input and result registers.
// Reset (rst, synchronous, active high): pipeline empty, parser idle,
// CRC at 0xFFFF, configuration registers at their defaults.
module sensor_frame_checker_crc16 import sfc_pkg::*; #(
  parameter int MAX_LENGTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sfc_byte_if.sink              frame_bytes,
  sfc_result_if.source          results
);

  cfg_t       cfg;

  // input register stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;

  // result register stage
  logic       out_valid;
  result_t    out_res;

  logic       step;
  logic       res_valid;
  result_t    res;

  // advance the input stage whenever the result register is free or draining
  assign step              = in_valid && (!out_valid || results.ready);
  assign frame_bytes.ready = !in_valid || step;

  sfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfc_parser #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (in_byte),
    .frame_first (in_first),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  // hold the input transaction until the parser consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame_bytes.valid && frame_bytes.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_bytes.valid && frame_bytes.ready) begin
      in_byte  <= frame_bytes.data_byte;
      in_first <= frame_bytes.frame_first;
    end
  end

  // result register: load on a producing step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign results.valid          = out_valid;
  assign results.status         = out_res.status;
  assign results.port           = out_res.port;
  assign results.sensor_match   = out_res.sensor_match;
  assign results.value_bits     = out_res.value_bits;
  assign results.received_check = out_res.received_check;
  assign results.computed_check = out_res.computed_check;

endmodule

// ===== src/sfc_cfg_regs.sv =====
module sfc_cfg_regs import sfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_word      <= 16'hAA55;
      cfg.message_type    <= 16'h0000;
      cfg.expected_length <= 7'd8;
      cfg.sensor_code     <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_WORD:      cfg.start_word      <= cfg_data;
        CFG_MESSAGE_TYPE:    cfg.message_type    <= cfg_data;
        CFG_EXPECTED_LENGTH: cfg.expected_length <= cfg_data[6:0];
        CFG_SENSOR_CODE:     cfg.sensor_code     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/sfc_parser.sv =====
module sfc_parser import sfc_pkg::*; #(
  parameter int MAX_LENGTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       frame_first,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  localparam int POS_W = $clog2(MAX_LENGTH + 6);
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             receiving, receiving_next;
  logic [15:0]      crc_register, crc_register_next;
  logic [15:0]      word_holder, word_holder_next;
  logic [7:0]       port_hold, port_hold_next;
  logic [7:0]       sensor_hold, sensor_hold_next;
  logic [31:0]      value_hold, value_hold_next;
  logic [LEN_W-1:0] length_hold, length_hold_next;

  logic [POS_W-1:0] pos_b;
  logic [15:0]      crc_b;
  logic [7:0]       port_b;
  logic [7:0]       sensor_b;
  logic [31:0]      value_b;
  logic [LEN_W-1:0] len_b;
  logic [15:0]      word;
  logic [15:0]      crc_upd;
  logic [POS_W:0]   pos_x;
  logic [POS_W:0]   crc_lo_pos;
  logic [POS_W:0]   pay_idx;
  logic             match;

  always_comb begin
    // a frame start discards whatever was held
    pos_b    = frame_first ? '0 : byte_position;
    crc_b    = frame_first ? CRC_INIT : crc_register;
    port_b   = frame_first ? 8'h00 : port_hold;
    sensor_b = frame_first ? 8'h00 : sensor_hold;
    value_b  = frame_first ? 32'h0 : value_hold;
    len_b    = frame_first ? '0 : length_hold;
    word     = {(frame_first ? 8'h00 : word_holder[7:0]), data_byte};
    crc_upd  = crc16_byte(crc_b, data_byte);

    pos_x      = {1'b0, pos_b};
    crc_lo_pos = (POS_W + 1)'(len_b) + (POS_W + 1)'(4);
    pay_idx    = pos_x - (POS_W + 1)'(HDR_BYTES);
    match      = (sensor_b == cfg.sensor_code);

    byte_position_next = byte_position;
    receiving_next     = receiving;
    crc_register_next  = crc_register;
    word_holder_next   = word_holder;
    port_hold_next     = port_hold;
    sensor_hold_next   = sensor_hold;
    value_hold_next    = value_hold;
    length_hold_next   = length_hold;
    res_valid          = 1'b0;
    res                = '0;

    if (step && (frame_first || receiving)) begin
      receiving_next     = 1'b1;
      word_holder_next   = word;
      byte_position_next = pos_b + POS_W'(1);
      crc_register_next  = crc_b;
      port_hold_next     = port_b;
      sensor_hold_next   = sensor_b;
      value_hold_next    = value_b;
      length_hold_next   = len_b;

      if (pos_x < (POS_W + 1)'(HDR_BYTES)) begin
        crc_register_next = crc_upd;
        if (pos_x == (POS_W + 1)'(1) && word != cfg.start_word) begin
          receiving_next = 1'b0;
          res_valid      = 1'b1;
          res.status     = ST_BAD_START;
        end else if (pos_x == (POS_W + 1)'(3) && word != cfg.message_type) begin
          receiving_next = 1'b0;
          res_valid      = 1'b1;
          res.status     = ST_BAD_TYPE;
        end else if (pos_x == (POS_W + 1)'(5)) begin
          if (word != {9'b0, cfg.expected_length} || word < 16'(MIN_LENGTH) ||
              word > 16'(MAX_LENGTH)) begin
            receiving_next = 1'b0;
            res_valid      = 1'b1;
            res.status     = ST_BAD_LENGTH;
          end else begin
            length_hold_next = word[LEN_W-1:0];
          end
        end
      end else if (pos_x < crc_lo_pos) begin
        // payload byte: capture port, sensor code and value bytes
        crc_register_next = crc_upd;
        if (pay_idx == '0) begin
          port_hold_next = data_byte;
        end else if (pay_idx == (POS_W + 1)'(1)) begin
          sensor_hold_next = data_byte;
        end else if (pay_idx < (POS_W + 1)'(6)) begin
          value_hold_next = {value_b[23:0], data_byte};
        end
      end else if (pos_x != crc_lo_pos) begin
        // second checksum byte closes the frame
        receiving_next     = 1'b0;
        byte_position_next = '0;
        res_valid          = 1'b1;
        res.received_check = word;
        res.computed_check = crc_b;
        if (word != crc_b) begin
          res.status = ST_BAD_CHECK;
        end else begin
          res.status       = ST_OK;
          res.port         = port_b;
          res.sensor_match = match;
          res.value_bits   = match ? value_b : 32'h0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      receiving     <= 1'b0;
      crc_register  <= CRC_INIT;
      word_holder   <= '0;
      port_hold     <= '0;
      sensor_hold   <= '0;
      value_hold    <= '0;
      length_hold   <= '0;
    end else begin
      byte_position <= byte_position_next;
      receiving     <= receiving_next;
      crc_register  <= crc_register_next;
      word_holder   <= word_holder_next;
      port_hold     <= port_hold_next;
      sensor_hold   <= sensor_hold_next;
      value_hold    <= value_hold_next;
      length_hold   <= length_hold_next;
    end
  end

endmodule
